FILE: rtl/pcm_stream_lifecycle_checker_top_defines.svh
// Assertion macros for the checker file of the stream lifecycle checker.
// Depends on nothing; the asserting module must provide clk_i and rst_ni.
`ifndef PCM_STREAM_LIFECYCLE_CHECKER_TOP_DEFINES_SVH
`define PCM_STREAM_LIFECYCLE_CHECKER_TOP_DEFINES_SVH

// Plain property, sampled on the rising clock and skipped during reset.
`define PCM_SLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication from an antecedent to a consequent.
`define PCM_SLC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication from an antecedent to a consequent.
`define PCM_SLC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/pcm_slc_pkg.sv
// Package of the stream lifecycle checker: codes, constants and item types.
// Used by every module of the block; depends on nothing.
package pcm_slc_pkg;

  // Slot geometry.
  localparam logic [15:0] QUANTUM_FRAMES  = 16'd256;
  localparam int          BYTES_PER_FRAME = 4;
  localparam int          BYTES_W         = 21;

  // Stream widths.
  localparam int S_TDATA_W = 128;
  localparam int S_TUSER_W = 2;
  localparam int M_TDATA_W = 136;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_STEP   = 2'd1,
    CMD_FINISH = 2'd2,
    CMD_ABORT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    SINK_ACCEPT  = 2'd0,
    SINK_RETRY   = 2'd1,
    SINK_FATAL   = 2'd2,
    SINK_UNKNOWN = 2'd3
  } sink_e;

  typedef enum logic [1:0] {
    RING_PRESENT = 2'd0,
    RING_EMPTY   = 2'd1,
    RING_ERROR   = 2'd2
  } ring_e;

  typedef enum logic [2:0] {
    PH_INITIAL  = 3'd0,
    PH_STARTED  = 3'd1,
    PH_FAILED   = 3'd2,
    PH_FINISHED = 3'd3,
    PH_ABORTED  = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_RETRY    = 3'd1,
    ST_FATAL    = 3'd2,
    ST_STATE    = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_RING     = 3'd5,
    ST_SLOT     = 3'd6,
    ST_CONSUMED = 3'd7
  } status_e;

  // One command item as held in the input register.
  typedef struct packed {
    cmd_e        cmd;
    sink_e       sink_result;
    logic [1:0]  head_peek;
    logic        ring_drained;
    logic        consume_ok;
    logic [15:0] slot_frames;
    logic [31:0] slot_sequence;
    logic [63:0] slot_offset;
    logic [7:0]  slot_flags;
  } item_t;

  // One result item as held in the result register.
  typedef struct packed {
    status_e     status;
    phase_e      lifecycle;
    logic        issue_submit;
    logic        issue_consume;
    logic [63:0] frames_total;
    logic [63:0] bytes_total;
  } result_t;

endpackage

FILE: rtl/pcm_slc_in_reg.sv
// Input register of the stream lifecycle checker: unpacks and holds one item.
// Depends on pcm_slc_pkg.
module pcm_slc_in_reg import pcm_slc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [S_TDATA_W-1:0] s_data_i,
  input  logic [S_TUSER_W-1:0] s_user_i,
  input  logic                 take_i,
  output logic                 valid_o,
  output item_t                item_o
);

  logic  valid_q;
  item_t item_q;
  item_t item_d;
  logic  load;

  // The register is free when empty or when its item moves on this cycle.
  assign s_ready_o = !valid_q || take_i;
  assign load      = s_valid_i && s_ready_o;

  // Unpack the stream word into item fields.
  always_comb begin
    item_d.cmd           = cmd_e'(s_user_i);
    item_d.sink_result   = sink_e'(s_data_i[1:0]);
    item_d.head_peek     = s_data_i[3:2];
    item_d.ring_drained  = s_data_i[4];
    item_d.consume_ok    = s_data_i[5];
    item_d.slot_frames   = s_data_i[21:6];
    item_d.slot_sequence = s_data_i[53:22];
    item_d.slot_offset   = s_data_i[117:54];
    item_d.slot_flags    = s_data_i[125:118];
  end

  // Occupancy flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/pcm_slc_core.sv
// Lifecycle core: phase machine, slot checks, expected sequence and offset,
// and the 64-bit totals. Depends on pcm_slc_pkg.
module pcm_slc_core import pcm_slc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        fire_i,
  input  item_t       item_i,
  output result_t     result_o
);

  phase_e       phase_q, phase_d;
  logic [31:0]  next_seq_q;
  logic [63:0]  next_off_q;
  logic [63:0]  frames_q;
  logic [63:0]  bytes_q;
  logic [7:0]   partial_flag_q;

  logic         phase_ok;
  logic         sink_acc;
  logic         sink_retry;
  logic         slot_full;
  logic         slot_partial;
  logic         slot_ok;
  logic [BYTES_W-1:0] slot_bytes;
  logic [64:0]  frames_sum;
  logic [64:0]  bytes_sum;
  logic         total_ovf;
  status_e      status;
  logic         submit;
  logic         consume;

  // Decode of the command against the current phase and the slot header.
  always_comb begin
    case (item_i.cmd)
      CMD_START:  phase_ok = (phase_q == PH_INITIAL);
      CMD_STEP:   phase_ok = (phase_q == PH_STARTED);
      CMD_FINISH: phase_ok = (phase_q == PH_STARTED) && item_i.ring_drained;
      CMD_ABORT:  phase_ok = (phase_q == PH_STARTED) || (phase_q == PH_FAILED);
      default:    phase_ok = 1'b0;
    endcase
    sink_acc     = (item_i.sink_result == SINK_ACCEPT);
    sink_retry   = (item_i.sink_result == SINK_RETRY);
    slot_full    = (item_i.slot_frames == QUANTUM_FRAMES);
    slot_partial = (item_i.slot_frames != 16'd0) && (item_i.slot_frames < QUANTUM_FRAMES);
    slot_ok      = (slot_full || slot_partial)
                && (item_i.slot_sequence == next_seq_q)
                && (item_i.slot_offset == next_off_q)
                && (slot_full ? (item_i.slot_flags == 8'd0)
                              : (item_i.slot_flags == partial_flag_q));
    slot_bytes   = BYTES_W'(item_i.slot_frames) * BYTES_W'(BYTES_PER_FRAME);
    frames_sum   = {1'b0, frames_q} + 65'(item_i.slot_frames);
    bytes_sum    = {1'b0, bytes_q} + 65'(slot_bytes);
    total_ovf    = frames_sum[64] || bytes_sum[64];
  end

  // Next phase.
  always_comb begin
    phase_d = phase_q;
    if (phase_ok) begin
      if (item_i.cmd == CMD_STEP) begin
        if ((item_i.head_peek == RING_PRESENT) && slot_ok && !sink_retry) begin
          if (!sink_acc || total_ovf || !item_i.consume_ok) begin
            phase_d = PH_FAILED;
          end
        end
      end else if (sink_acc) begin
        case (item_i.cmd)
          CMD_START:  phase_d = PH_STARTED;
          CMD_FINISH: phase_d = PH_FINISHED;
          default:    phase_d = PH_ABORTED;
        endcase
      end else if (!sink_retry) begin
        phase_d = PH_FAILED;
      end
    end
  end

  // Status and issue flags.
  always_comb begin
    status  = ST_OK;
    submit  = 1'b0;
    consume = 1'b0;
    if (!phase_ok) begin
      status = ST_STATE;
    end else if (item_i.cmd != CMD_STEP) begin
      status = sink_acc ? ST_OK : (sink_retry ? ST_RETRY : ST_FATAL);
    end else if (item_i.head_peek == RING_EMPTY) begin
      status = ST_EMPTY;
    end else if (item_i.head_peek != RING_PRESENT) begin
      status = ST_RING;
    end else if (!slot_ok) begin
      status = ST_SLOT;
    end else begin
      submit = 1'b1;
      if (sink_retry) begin
        status = ST_RETRY;
      end else if (!sink_acc || total_ovf) begin
        status = ST_FATAL;
      end else if (!item_i.consume_ok) begin
        status = ST_RING;
      end else begin
        status  = ST_CONSUMED;
        consume = 1'b1;
      end
    end
  end

  // Result seen after this item.
  always_comb begin
    result_o.status        = status;
    result_o.lifecycle     = phase_d;
    result_o.issue_submit  = submit;
    result_o.issue_consume = consume;
    result_o.frames_total  = consume ? frames_sum[63:0] : frames_q;
    result_o.bytes_total   = consume ? bytes_sum[63:0] : bytes_q;
  end

  // Stream state; it advances only when an item is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_INITIAL;
      next_seq_q <= 32'd0;
      next_off_q <= 64'd0;
      frames_q   <= 64'd0;
      bytes_q    <= 64'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      if (consume) begin
        next_seq_q <= next_seq_q + 32'd1;
        next_off_q <= next_off_q + 64'(item_i.slot_frames);
        frames_q   <= frames_sum[63:0];
        bytes_q    <= bytes_sum[63:0];
      end
    end
  end

  // Flag value required on a short final slot.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_flag_q <= 8'd1;
    end else if (cfg_we_i) begin
      partial_flag_q <= cfg_wdata_i;
    end
  end

endmodule

FILE: rtl/pcm_slc_out_reg.sv
// Result register of the stream lifecycle checker: holds and packs one result.
// Depends on pcm_slc_pkg.
module pcm_slc_out_reg import pcm_slc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  result_t              result_i,
  output logic                 free_o,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output logic [M_TDATA_W-1:0] m_data_o
);

  logic    valid_q;
  result_t result_q;

  // Free when empty or when the held result is taken this cycle.
  assign free_o = !valid_q || m_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  // Pack the result, first field in the lowest bits.
  assign m_valid_o         = valid_q;
  assign m_data_o[2:0]     = result_q.status;
  assign m_data_o[5:3]     = result_q.lifecycle;
  assign m_data_o[6]       = result_q.issue_submit;
  assign m_data_o[7]       = result_q.issue_consume;
  assign m_data_o[71:8]    = result_q.frames_total;
  assign m_data_o[135:72]  = result_q.bytes_total;

endmodule

FILE: rtl/pcm_stream_lifecycle_checker_top.sv
// Top level of the stream lifecycle checker: input register, lifecycle core
// and result register. Depends on pcm_slc_pkg and the three submodules.
//
//   port group  direction  carries
//   s_axis      in         one command item per transfer
//   m_axis      out        one result item per command
//   cfg         in         final_partial_flag write
//
// Each item is held in the input register until the result register is free;
// the core evaluates it combinationally and its result is registered as it leaves.
// Throughput is one item per cycle while m_axis does not stall.
// Reset returns the phase to initial, clears sequence, offset and totals, and
// sets final_partial_flag to 1. A stalled m_axis holds its result, and the
// input register still takes one more item behind it.
module pcm_stream_lifecycle_checker_top import pcm_slc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // sink_result[1:0] head_peek[3:2] ring_drained[4] consume_ok[5]
  // slot_frames[21:6] slot_sequence[53:22] slot_offset[117:54]
  // slot_flags[125:118], zero above
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // cmd[1:0]
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[2:0] lifecycle[5:3] issue_submit[6] issue_consume[7]
  // frames_total[71:8] bytes_total[135:72]
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i
);

  logic    in_valid;
  item_t   item;
  result_t result;
  logic    out_free;
  logic    fire;

  // An item is processed when it is held and the result register can take it.
  assign fire = in_valid && out_free;

  pcm_slc_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_data_i  (s_axis_tdata),
    .s_user_i  (s_axis_tuser),
    .take_i    (fire),
    .valid_o   (in_valid),
    .item_o    (item)
  );

  pcm_slc_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .item_i      (item),
    .result_o    (result)
  );

  pcm_slc_out_reg u_out_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (fire),
    .result_i  (result),
    .free_o    (out_free),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

FILE: rtl/pcm_slc_checker.sv
// Port-level checker for the stream lifecycle checker, bound to the top level.
// Depends on pcm_slc_pkg and pcm_stream_lifecycle_checker_top_defines.svh.
`include "pcm_stream_lifecycle_checker_top_defines.svh"

module pcm_slc_checker import pcm_slc_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 s_axis_tready,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [M_TDATA_W-1:0] m_axis_tdata
);

  logic [63:0] last_frames_q;
  logic        out_take;
  logic        out_stall;
  logic [2:0]  out_status;
  logic        out_submit;
  logic        out_cons;
  logic        cons_ok;
  logic [63:0] out_frames;
  logic [63:0] out_bytes;
  logic        bytes_ok;

  // Result fields and handshake terms seen on the ports.
  assign out_take   = m_axis_tvalid && m_axis_tready;
  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_status = m_axis_tdata[2:0];
  assign out_submit = m_axis_tdata[6];
  assign out_cons   = m_axis_tvalid && m_axis_tdata[7];
  assign out_frames = m_axis_tdata[71:8];
  assign out_bytes  = m_axis_tdata[135:72];
  assign cons_ok    = out_submit && (out_status == ST_CONSUMED);
  assign bytes_ok   = (out_bytes == 64'(out_frames * 64'(BYTES_PER_FRAME)));

  // Frame total of the last delivered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_frames_q <= 64'd0;
    end else if (out_take) begin
      last_frames_q <= out_frames;
    end
  end

  // A stalled result keeps its value.
  `PCM_SLC_ASSERT_NXT(a_out_hold, out_stall, $stable(m_axis_tdata), "stalled result changed")

  // A consume only follows a submit and reports consumed.
  `PCM_SLC_ASSERT_IMP(a_consume_status, out_cons, cons_ok, "consume without submit or status")

  // Byte total always tracks the frame total, since neither may wrap.
  `PCM_SLC_ASSERT_IMP(a_bytes_track, m_axis_tvalid, bytes_ok, "byte total out of step")

  // Frame total never falls between delivered results.
  `PCM_SLC_ASSERT_IMP(a_frames_mono, out_take, out_frames >= last_frames_q, "frame total fell")

  // The input side always has room when no result is waiting.
  `PCM_SLC_ASSERT(a_in_room, m_axis_tvalid || s_axis_tready, "input stalled with empty output")

endmodule

bind pcm_stream_lifecycle_checker_top pcm_slc_checker u_pcm_slc_checker (.*);

FILE: sim/pcm_slc_result_checker.sv
// Result checker for the stream lifecycle checker testbench: predicts every result item
// from the accepted commands and register writes and compares it field by field.
// Depends on pcm_slc_pkg; instantiated beside the block by the testbench top.
module pcm_slc_result_checker import pcm_slc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  // sink_result[1:0] head_peek[3:2] ring_drained[4] consume_ok[5]
  // slot_frames[21:6] slot_sequence[53:22] slot_offset[117:54] slot_flags[125:118]
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  // cmd[1:0]
  input  logic [S_TUSER_W-1:0] s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  // status[2:0] lifecycle[5:3] issue_submit[6] issue_consume[7]
  // frames_total[71:8] bytes_total[135:72]
  input  logic [M_TDATA_W-1:0] m_tdata_i,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  output int                   mismatches_o,
  output int                   pending_o
);

  localparam int REPORT_LIMIT = 10;

  // Predicted state of the stream and the register copy.
  phase_e      life_phase      = PH_INITIAL;
  logic [31:0] seq_expected    = '0;
  logic [63:0] offset_expected = '0;
  logic [63:0] frames_accepted = '0;
  logic [63:0] bytes_accepted  = '0;
  logic [7:0]  partial_flag    = 8'd1;

  result_t     expected_results[$];
  int          mismatches = 0;

  // Sink answer to status; a fatal or unknown answer fails the stream.
  function automatic status_e sink_verdict(sink_e answer);
    if (answer == SINK_ACCEPT) return ST_OK;
    if (answer == SINK_RETRY) return ST_RETRY;
    life_phase = PH_FAILED;
    return ST_FATAL;
  endfunction

  // Apply one command to the predicted state and return the result it yields.
  function automatic result_t predict_result(item_t cmd_item);
    result_t     res;
    status_e     st;
    logic        full;
    logic        partial;
    logic        slot_ok;
    logic [63:0] frames64;
    logic [63:0] bytes64;
    st       = ST_OK;
    res.issue_submit  = 1'b0;
    res.issue_consume = 1'b0;
    frames64 = {48'd0, cmd_item.slot_frames};
    bytes64  = frames64 * 64'(BYTES_PER_FRAME);
    full     = (cmd_item.slot_frames == QUANTUM_FRAMES);
    partial  = (cmd_item.slot_frames != 16'd0) && (cmd_item.slot_frames < QUANTUM_FRAMES);
    case (cmd_item.cmd)
      CMD_START: begin
        if (life_phase != PH_INITIAL) st = ST_STATE;
        else begin
          st = sink_verdict(cmd_item.sink_result);
          if (st == ST_OK) life_phase = PH_STARTED;
        end
      end
      CMD_STEP: begin
        if (life_phase != PH_STARTED) st = ST_STATE;
        else if (cmd_item.head_peek == RING_EMPTY) st = ST_EMPTY;
        else if (cmd_item.head_peek != RING_PRESENT) st = ST_RING;
        else begin
          slot_ok = (full || partial) && (cmd_item.slot_sequence == seq_expected) &&
                    (cmd_item.slot_offset == offset_expected) &&
                    (full ? (cmd_item.slot_flags == 8'd0)
                          : (cmd_item.slot_flags == partial_flag));
          if (!slot_ok) st = ST_SLOT;
          else begin
            res.issue_submit = 1'b1;
            st = sink_verdict(cmd_item.sink_result);
            if (st == ST_OK) begin
              // Adding x to a total wraps exactly when the total exceeds ~x.
              if ((frames_accepted > ~frames64) || (bytes_accepted > ~bytes64)) begin
                life_phase = PH_FAILED;
                st = ST_FATAL;
              end else if (!cmd_item.consume_ok) begin
                life_phase = PH_FAILED;
                st = ST_RING;
              end else begin
                res.issue_consume = 1'b1;
                offset_expected   = offset_expected + frames64;
                frames_accepted   = frames_accepted + frames64;
                bytes_accepted    = bytes_accepted + bytes64;
                seq_expected      = seq_expected + 32'd1;
                st = ST_CONSUMED;
              end
            end
          end
        end
      end
      CMD_FINISH: begin
        if ((life_phase != PH_STARTED) || !cmd_item.ring_drained) st = ST_STATE;
        else begin
          st = sink_verdict(cmd_item.sink_result);
          if (st == ST_OK) life_phase = PH_FINISHED;
        end
      end
      default: begin
        if ((life_phase != PH_STARTED) && (life_phase != PH_FAILED)) st = ST_STATE;
        else begin
          st = sink_verdict(cmd_item.sink_result);
          if (st == ST_OK) life_phase = PH_ABORTED;
        end
      end
    endcase
    res.status       = st;
    res.lifecycle    = life_phase;
    res.frames_total = frames_accepted;
    res.bytes_total  = bytes_accepted;
    return res;
  endfunction

  // Count a wrong field and report the first few.
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= REPORT_LIMIT) begin
        $display("%0t: result field %s differs: expected %0h, got %0h", $realtime, name,
                 want, got);
      end
    end
  endtask

  // Compare results first, then predict the command of the same edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    item_t   cmd_item;
    result_t got;
    result_t want;
    if (!rst_ni) begin
      life_phase      = PH_INITIAL;
      seq_expected    = '0;
      offset_expected = '0;
      frames_accepted = '0;
      bytes_accepted  = '0;
      partial_flag    = 8'd1;
      expected_results.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) partial_flag = cfg_wdata_i;
      if (m_tvalid_i && m_tready_i) begin
        got.status        = status_e'(m_tdata_i[2:0]);
        got.lifecycle     = phase_e'(m_tdata_i[5:3]);
        got.issue_submit  = m_tdata_i[6];
        got.issue_consume = m_tdata_i[7];
        got.frames_total  = m_tdata_i[71:8];
        got.bytes_total   = m_tdata_i[135:72];
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("%0t: result item with no command waiting: status %0d", $realtime,
                     got.status);
          end
        end else begin
          want = expected_results.pop_front();
          check_field("status", 64'(want.status), 64'(got.status));
          check_field("lifecycle", 64'(want.lifecycle), 64'(got.lifecycle));
          check_field("issue_submit", 64'(want.issue_submit), 64'(got.issue_submit));
          check_field("issue_consume", 64'(want.issue_consume), 64'(got.issue_consume));
          check_field("frames_total", want.frames_total, got.frames_total);
          check_field("bytes_total", want.bytes_total, got.bytes_total);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        cmd_item.cmd           = cmd_e'(s_tuser_i[1:0]);
        cmd_item.sink_result   = sink_e'(s_tdata_i[1:0]);
        cmd_item.head_peek     = s_tdata_i[3:2];
        cmd_item.ring_drained  = s_tdata_i[4];
        cmd_item.consume_ok    = s_tdata_i[5];
        cmd_item.slot_frames   = s_tdata_i[21:6];
        cmd_item.slot_sequence = s_tdata_i[53:22];
        cmd_item.slot_offset   = s_tdata_i[117:54];
        cmd_item.slot_flags    = s_tdata_i[125:118];
        expected_results.push_back(predict_result(cmd_item));
      end
      pending_o    <= expected_results.size();
      mismatches_o <= mismatches;
    end
  end

endmodule

FILE: sim/tb_pcm_stream_lifecycle_checker_top.sv
// Testbench top of the stream lifecycle checker: clock, reset, command stimulus,
// result back-pressure, watchdog and verdict. Depends on pcm_slc_pkg, the block
// and the result checker.
module tb_pcm_stream_lifecycle_checker_top import pcm_slc_pkg::*; ();

  localparam int          STALL_LIMIT    = 1000;
  localparam int          DRAIN_CYCLES   = 10;
  localparam int          PHASE_ITEMS    = 420;
  localparam int          TAIL_ITEMS     = 40;
  localparam logic [1:0]  RING_UNDEFINED = 2'd3;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [S_TUSER_W-1:0] s_axis_tuser  = '0;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [7:0]           cfg_wdata_i   = '0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  int                   mismatches;
  int                   pending;
  int unsigned          stall_cycles = 0;

  // Where the stimulus believes the stream stands, used to build well-formed slots.
  logic [31:0]          cur_seq  = '0;
  logic [63:0]          cur_off  = '0;
  logic [7:0]           cur_flag = 8'd1;
  bit                   tx_calm  = 1'b0;

  pcm_stream_lifecycle_checker_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  pcm_slc_result_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic item_t make_item(cmd_e cmd, sink_e sink, logic [1:0] ring,
                                      logic drained, logic cons, logic [15:0] frames,
                                      logic [31:0] seq, logic [63:0] off,
                                      logic [7:0] flags);
    item_t it;
    it.cmd           = cmd;
    it.sink_result   = sink;
    it.head_peek     = ring;
    it.ring_drained  = drained;
    it.consume_ok    = cons;
    it.slot_frames   = frames;
    it.slot_sequence = seq;
    it.slot_offset   = off;
    it.slot_flags    = flags;
    return it;
  endfunction

  // A step whose slot header matches the stream position and the flag rule.
  function automatic item_t good_step(logic [15:0] frames, sink_e sink);
    return make_item(CMD_STEP, sink, RING_PRESENT, 1'b1, 1'b1, frames, cur_seq, cur_off,
                     (frames == QUANTUM_FRAMES) ? 8'd0 : cur_flag);
  endfunction

  function automatic item_t any_item();
    return make_item(cmd_e'($urandom_range(0, 3)), sink_e'($urandom_range(0, 3)),
                     2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 16'($urandom), $urandom, rand64(),
                     8'($urandom));
  endfunction

  // Item for a live stream: mostly well-formed steps, some broken slots, ring
  // trouble and commands that leave the stream started.
  function automatic item_t live_item(output bit adv);
    item_t       it;
    int unsigned pick;
    int unsigned k;
    logic [15:0] frames;
    adv  = 1'b0;
    it   = any_item();
    pick = $urandom_range(0, 99);
    if (pick < 80) begin
      k = $urandom_range(0, 99);
      if (k < 55) frames = QUANTUM_FRAMES;
      else if (k < 65) frames = 16'd1;
      else if (k < 75) frames = QUANTUM_FRAMES - 16'd1;
      else frames = 16'($urandom_range(1, QUANTUM_FRAMES - 1));
      if (pick < 70) begin
        it = good_step(frames, ($urandom_range(0, 6) == 0) ? SINK_RETRY : SINK_ACCEPT);
        if (it.sink_result == SINK_RETRY) it.consume_ok = 1'($urandom_range(0, 1));
        adv = (it.sink_result == SINK_ACCEPT);
      end else begin
        // Broken slot: one header field is off, the sink is never asked.
        it = good_step(frames, sink_e'($urandom_range(0, 3)));
        it.consume_ok = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 5))
          0: it.slot_frames = 16'd0;
          1: it.slot_frames = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
                              16'($urandom_range(QUANTUM_FRAMES + 1, 16'hFFFF));
          2: it.slot_sequence ^= 32'd1 << $urandom_range(0, 31);
          3: it.slot_offset ^= 64'd1 << $urandom_range(0, 63);
          4: it.slot_flags ^= 8'd1 << $urandom_range(0, 7);
          default: it.slot_sequence = cur_seq - 32'd1;
        endcase
      end
    end else if (pick < 88) begin
      it.cmd       = CMD_STEP;
      it.head_peek = 2'($urandom_range(1, 3));
    end else begin
      case ($urandom_range(0, 3))
        0: it.cmd = CMD_START;
        1: begin
          it.cmd          = CMD_FINISH;
          it.ring_drained = 1'b0;
        end
        2: begin
          it.cmd          = CMD_FINISH;
          it.ring_drained = 1'b1;
          it.sink_result  = SINK_RETRY;
        end
        default: begin
          it.cmd         = CMD_ABORT;
          it.sink_result = SINK_RETRY;
        end
      endcase
    end
    return it;
  endfunction

  // Offer one command after a random gap and hold it until it is taken.
  task automatic send_item(item_t it, bit advances);
    int unsigned gap;
    gap = tx_calm ? 0 : idle_len();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, it.slot_flags, it.slot_offset, it.slot_sequence,
                      it.slot_frames, it.consume_ok, it.ring_drained, it.head_peek,
                      it.sink_result};
    s_axis_tuser  <= it.cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (advances) begin
      cur_seq = cur_seq + 32'd1;
      cur_off = cur_off + {48'd0, it.slot_frames};
    end
  endtask

  // Let every result drain, then write the partial-slot flag.
  task automatic reconfigure(logic [7:0] value);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_flag = value;
    @(posedge clk_i);
  endtask

  // Result side: ready bursts broken by stalls, now and then a long free stretch.
  initial begin : result_sink
    int unsigned hold;
    int unsigned busy;
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      hold = ($urandom_range(0, 9) == 0) ? 100 : $urandom_range(1, 12);
      repeat (hold) @(posedge clk_i);
      busy = idle_len();
      if (busy != 0) begin
        m_axis_tready <= 1'b0;
        repeat (busy) @(posedge clk_i);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Command stimulus and verdict.
  initial begin : stimulus
    item_t       it;
    bit          adv;
    bit          stream_failed;
    logic [7:0]  phase_flags[4];
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    reconfigure(8'd1);

    // Wrong phase before start, start retried, then started, then a second start refused.
    send_item(good_step(QUANTUM_FRAMES, SINK_ACCEPT), 1'b0);
    send_item(make_item(CMD_FINISH, SINK_ACCEPT, RING_PRESENT, 1'b1, 1'b1, '0, '0, '0, '0),
              1'b0);
    send_item(make_item(CMD_ABORT, SINK_ACCEPT, RING_PRESENT, 1'b1, 1'b1, '0, '0, '0, '0),
              1'b0);
    send_item(make_item(CMD_START, SINK_RETRY, RING_PRESENT, 1'b0, 1'b0, '0, '0, '0, '0),
              1'b0);
    send_item(make_item(CMD_START, SINK_ACCEPT, RING_PRESENT, 1'b0, 1'b0, '0, '0, '0, '0),
              1'b0);
    send_item(make_item(CMD_START, SINK_ACCEPT, RING_PRESENT, 1'b0, 1'b0, '0, '0, '0, '0),
              1'b0);

    // Ring empty, ring error and the undefined ring status.
    it = good_step(QUANTUM_FRAMES, SINK_ACCEPT);
    it.head_peek = RING_EMPTY;
    send_item(it, 1'b0);
    it.head_peek = RING_ERROR;
    send_item(it, 1'b0);
    it.head_peek = RING_UNDEFINED;
    send_item(it, 1'b0);

    // Slot errors: frame count, extremes, flags, sequence and offset.
    send_item(good_step(16'd0, SINK_ACCEPT), 1'b0);
    send_item(good_step(QUANTUM_FRAMES + 16'd1, SINK_ACCEPT), 1'b0);
    send_item(make_item(CMD_STEP, SINK_UNKNOWN, RING_PRESENT, 1'b1, 1'b0, 16'hFFFF, '1, '1,
                        8'hFF), 1'b0);
    it = good_step(QUANTUM_FRAMES, SINK_ACCEPT);
    it.slot_flags = 8'h80;
    send_item(it, 1'b0);
    it = good_step(QUANTUM_FRAMES, SINK_ACCEPT);
    it.slot_sequence = cur_seq + 32'd1;
    send_item(it, 1'b0);
    it = good_step(QUANTUM_FRAMES, SINK_ACCEPT);
    it.slot_offset = cur_off ^ {1'b1, 63'd0};
    send_item(it, 1'b0);
    it = good_step(16'd100, SINK_ACCEPT);
    it.slot_flags = 8'd0;
    send_item(it, 1'b0);

    // Sink retry on a good slot, then full and partial slots consumed.
    send_item(good_step(QUANTUM_FRAMES, SINK_RETRY), 1'b0);
    send_item(good_step(QUANTUM_FRAMES, SINK_ACCEPT), 1'b1);
    send_item(good_step(16'd1, SINK_ACCEPT), 1'b1);
    send_item(good_step(QUANTUM_FRAMES - 16'd1, SINK_ACCEPT), 1'b1);

    // Finish with the ring not drained, finish and abort retried.
    send_item(make_item(CMD_FINISH, SINK_ACCEPT, RING_PRESENT, 1'b0, 1'b1, '0, '0, '0, '0),
              1'b0);
    send_item(make_item(CMD_FINISH, SINK_RETRY, RING_PRESENT, 1'b1, 1'b1, '0, '0, '0, '0),
              1'b0);
    send_item(make_item(CMD_ABORT, SINK_RETRY, RING_PRESENT, 1'b1, 1'b1, '0, '0, '0, '0),
              1'b0);

    // Random traffic on a live stream under several flag settings.
    phase_flags[0] = 8'hFF;
    phase_flags[1] = 8'h00;
    phase_flags[2] = 8'($urandom);
    phase_flags[3] = 8'($urandom);
    for (int p = 0; p < 4; p++) begin
      reconfigure(phase_flags[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if ((i % 64) == 0) tx_calm = ($urandom_range(0, 3) == 0);
        it = live_item(adv);
        send_item(it, adv);
      end
    end
    tx_calm = 1'b0;

    // End the stream by one of the terminal paths.
    stream_failed = 1'b1;
    it = good_step(QUANTUM_FRAMES, SINK_ACCEPT);
    case ($urandom_range(0, 5))
      0: it.consume_ok = 1'b0;
      1: it.sink_result = SINK_FATAL;
      2: it.sink_result = SINK_UNKNOWN;
      3: begin
        it.cmd = CMD_FINISH;
        stream_failed = 1'b0;
      end
      4: begin
        it.cmd = CMD_ABORT;
        stream_failed = 1'b0;
      end
      default: begin
        it.cmd = CMD_ABORT;
        it.sink_result = SINK_UNKNOWN;
      end
    endcase
    send_item(it, 1'b0);

    // From failed, only abort is allowed.
    if (stream_failed) begin
      send_item(make_item(CMD_ABORT, SINK_RETRY, RING_PRESENT, 1'b1, 1'b1, '0, '0, '0, '0),
                1'b0);
      send_item(good_step(QUANTUM_FRAMES, SINK_ACCEPT), 1'b0);
      send_item(make_item(CMD_ABORT, SINK_ACCEPT, RING_PRESENT, 1'b1, 1'b1, '0, '0, '0, '0),
                1'b0);
    end

    // Anything after the stream has ended is a state error.
    for (int i = 0; i < TAIL_ITEMS; i++) begin
      send_item(any_item(), 1'b0);
    end

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if ((mismatches == 0) && (pending == 0)) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
